>>> design/hsse_pkg.sv
// shared types and constants for the hit squash scale envelope
package hsse_pkg;
  localparam int FRAC_BITS = 16;
  localparam logic [22:0] ELAPSED_MAX = 23'h7fffff;
  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_HIT  = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  localparam logic [2:0] REG_MULT_X   = 3'd0;
  localparam logic [2:0] REG_MULT_Y   = 3'd1;
  localparam logic [2:0] REG_MULT_Z   = 3'd2;
  localparam logic [2:0] REG_IN_T     = 3'd3;
  localparam logic [2:0] REG_HOLD_T   = 3'd4;
  localparam logic [2:0] REG_REC_T    = 3'd5;
  localparam logic [2:0] REG_COOL_T   = 3'd6;
  localparam logic [2:0] REG_MODE     = 3'd7;

  // phase chosen by the controller for a running tick
  localparam logic [1:0] PH_IN   = 2'd0;
  localparam logic [1:0] PH_HOLD = 2'd1;
  localparam logic [1:0] PH_REC  = 2'd2;
  localparam logic [1:0] PH_BASE = 2'd3;

  typedef struct packed {
    logic       load;      // capture the request
    logic       div_start; // start alpha division
    logic       ease_go;   // compute ease from alpha
    logic       comp_go;   // compute three components
    logic [1:0] phase;
  } hsse_cmd_t;

  typedef struct packed {
    logic div_done;
    logic ease_done;
    logic comp_done;
  } hsse_stat_t;
endpackage

>>> design/hit_squash_scale_envelope.sv
// top level of the hit squash scale envelope
// timing: hit, end of play, idle tick and a tick that writes base give a result the cycle
//   after the request; a hold tick runs the component steps, 4 per axis for 3 axes in turn;
//   an easing tick first runs the 39-step alpha divider and the ease cube, then those steps
// flow: one request at a time; the next is accepted the cycle after the result is taken
// reset: rst_n synchronous active low; envelope idle, cooldown and elapsed zero,
//   registers at their reset values; base scale undefined until the first hit
module hit_squash_scale_envelope (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [19:0]        in_delta_us,
  input  logic               in_hit_ok,
  input  logic signed [31:0] in_cur_x,
  input  logic signed [31:0] in_cur_y,
  input  logic signed [31:0] in_cur_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_scale_write,
  output logic signed [31:0] out_scale_x,
  output logic signed [31:0] out_scale_y,
  output logic signed [31:0] out_scale_z,
  output logic               out_busy_res,
  output logic               out_hit_taken,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import hsse_pkg::*;

  // configuration registers
  logic [18:0] mult_x_r, mult_y_r, mult_z_r;
  logic [20:0] in_t_r, hold_t_r, rec_t_r;
  logic [22:0] cool_t_r;
  logic [1:0]  mode_r;
  logic        wr_en;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_x_r <= 19'd65536;
      mult_y_r <= 19'd65536;
      mult_z_r <= 19'd65536;
      in_t_r <= '0;
      hold_t_r <= '0;
      rec_t_r <= '0;
      cool_t_r <= '0;
      mode_r <= 2'd2;
    end else if (wr_en) begin
      case (ridx)
        REG_MULT_X: mult_x_r <= pwdata[18:0];
        REG_MULT_Y: mult_y_r <= pwdata[18:0];
        REG_MULT_Z: mult_z_r <= pwdata[18:0];
        REG_IN_T:   in_t_r <= pwdata[20:0];
        REG_HOLD_T: hold_t_r <= pwdata[20:0];
        REG_REC_T:  rec_t_r <= pwdata[20:0];
        REG_COOL_T: cool_t_r <= pwdata[22:0];
        REG_MODE:   mode_r <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_MULT_X: prdata = 32'(mult_x_r);
      REG_MULT_Y: prdata = 32'(mult_y_r);
      REG_MULT_Z: prdata = 32'(mult_z_r);
      REG_IN_T:   prdata = 32'(in_t_r);
      REG_HOLD_T: prdata = 32'(hold_t_r);
      REG_REC_T:  prdata = 32'(rec_t_r);
      REG_COOL_T: prdata = 32'(cool_t_r);
      default:    prdata = 32'(mode_r);
    endcase
  end

  // base scale, latched when a hit starts an idle envelope
  logic signed [31:0] base_x_r, base_y_r, base_z_r;
  logic               cap_base;
  always_ff @(posedge clk) begin
    if (cap_base) begin
      base_x_r <= in_cur_x;
      base_y_r <= in_cur_y;
      base_z_r <= in_cur_z;
    end
  end

  hsse_cmd_t  dp_cmd;
  hsse_stat_t dp_stat;
  logic [22:0] dp_t;
  logic [20:0] dp_len;
  logic        sel_base;
  logic signed [31:0] rx, ry, rz;

  hsse_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_delta_us(in_delta_us), .in_hit_ok(in_hit_ok),
    .in_t_in(in_t_r), .hold_t(hold_t_r), .rec_t(rec_t_r),
    .cool_t(cool_t_r), .mode(mode_r), .cap_base(cap_base),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_scale_write(out_scale_write), .out_busy_res(out_busy_res),
    .out_hit_taken(out_hit_taken), .res_sel_base(sel_base),
    .cmd_o(dp_cmd), .stat_i(dp_stat), .t_o(dp_t), .len_o(dp_len)
  );

  hsse_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd_i(dp_cmd), .stat_o(dp_stat),
    .t_i(dp_t), .len_i(dp_len),
    .base_x_i(base_x_r), .base_y_i(base_y_r), .base_z_i(base_z_r),
    .mult_x_i(mult_x_r), .mult_y_i(mult_y_r), .mult_z_i(mult_z_r),
    .res_x_o(rx), .res_y_o(ry), .res_z_o(rz)
  );

  // fields are zero when no scale is written; base goes straight out
  always_comb begin
    if (!out_scale_write) begin
      out_scale_x = '0;
      out_scale_y = '0;
      out_scale_z = '0;
    end else if (sel_base) begin
      out_scale_x = base_x_r;
      out_scale_y = base_y_r;
      out_scale_z = base_z_r;
    end else begin
      out_scale_x = rx;
      out_scale_y = ry;
      out_scale_z = rz;
    end
  end
endmodule

>>> design/hsse_datapath.sv
// datapath: alpha divider, ease polynomial and per-axis squash and lerp
module hsse_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  hsse_pkg::hsse_cmd_t  cmd_i,
  output hsse_pkg::hsse_stat_t stat_o,
  input  logic [22:0]        t_i,
  input  logic [20:0]        len_i,
  input  logic signed [31:0] base_x_i,
  input  logic signed [31:0] base_y_i,
  input  logic signed [31:0] base_z_i,
  input  logic [18:0]        mult_x_i,
  input  logic [18:0]        mult_y_i,
  input  logic [18:0]        mult_z_i,
  output logic signed [31:0] res_x_o,
  output logic signed [31:0] res_y_o,
  output logic signed [31:0] res_z_o
);
  import hsse_pkg::*;

  // restoring divider: (t << 16) / len, one quotient bit a cycle
  logic [38:0] dividend_r, dividend_nxt;
  logic [21:0] rem_r, rem_nxt;
  logic [5:0]  dcnt_r, dcnt_nxt;
  logic        dbusy_r, dbusy_nxt;
  logic        ddone_r, ddone_nxt;
  logic [16:0] alpha_r, alpha_nxt;
  logic [21:0] trial;

  always_comb begin
    dividend_nxt = dividend_r;
    rem_nxt = rem_r;
    dcnt_nxt = dcnt_r;
    dbusy_nxt = dbusy_r;
    ddone_nxt = 1'b0;
    alpha_nxt = alpha_r;
    trial = {rem_r[20:0], dividend_r[38]};
    if (cmd_i.div_start) begin
      if (len_i == 21'd0) begin
        alpha_nxt = ALPHA_ONE;
        ddone_nxt = 1'b1;
      end else begin
        dividend_nxt = {t_i, 16'd0};
        rem_nxt = '0;
        dcnt_nxt = 6'd39;
        dbusy_nxt = 1'b1;
      end
    end else if (dbusy_r) begin
      if (trial >= {1'b0, len_i}) begin
        rem_nxt = trial - {1'b0, len_i};
        dividend_nxt = {dividend_r[37:0], 1'b1};
      end else begin
        rem_nxt = trial;
        dividend_nxt = {dividend_r[37:0], 1'b0};
      end
      dcnt_nxt = dcnt_r - 6'd1;
      if (dcnt_r == 6'd1) begin
        dbusy_nxt = 1'b0;
        ddone_nxt = 1'b1;
        if (dividend_nxt > 39'd65536) alpha_nxt = ALPHA_ONE;
        else alpha_nxt = dividend_nxt[16:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      ddone_r <= 1'b0;
      dcnt_r <= '0;
    end else begin
      dbusy_r <= dbusy_nxt;
      ddone_r <= ddone_nxt;
      dcnt_r <= dcnt_nxt;
    end
    dividend_r <= dividend_nxt;
    rem_r <= rem_nxt;
    alpha_r <= alpha_nxt;
  end

  // ease: cube of a 17-bit value in two registered multiplies
  logic [2:0]  estep_r, estep_nxt;
  logic [16:0] eu_r, eu_nxt;
  logic [33:0] sq_r, sq_nxt;
  logic [50:0] cube_r, cube_nxt;
  logic [16:0] ease_r, ease_nxt;
  logic        edone_r;
  logic        rising_r, rising_nxt;
  logic        lowhalf_r, lowhalf_nxt;

  always_comb begin
    estep_nxt = estep_r;
    eu_nxt = eu_r;
    sq_nxt = sq_r;
    cube_nxt = cube_r;
    ease_nxt = ease_r;
    rising_nxt = rising_r;
    lowhalf_nxt = lowhalf_r;
    if (cmd_i.ease_go) begin
      estep_nxt = 3'd1;
      if (cmd_i.phase == PH_IN) begin
        eu_nxt = ALPHA_ONE - alpha_r;
        rising_nxt = 1'b0;
      end else if (alpha_r < 17'd32768) begin
        eu_nxt = alpha_r;
        rising_nxt = 1'b1;
        lowhalf_nxt = 1'b1;
      end else begin
        eu_nxt = 17'(18'd131072 - {alpha_r, 1'b0});
        rising_nxt = 1'b1;
        lowhalf_nxt = 1'b0;
      end
    end else if (estep_r == 3'd1) begin
      sq_nxt = 34'(eu_r) * 34'(eu_r);
      estep_nxt = 3'd2;
    end else if (estep_r == 3'd2) begin
      cube_nxt = 51'(sq_r) * 51'(eu_r);
      estep_nxt = 3'd3;
    end else if (estep_r == 3'd3) begin
      if (!rising_r) ease_nxt = ALPHA_ONE - 17'(cube_r >> 32);
      else if (lowhalf_r) ease_nxt = 17'(cube_r >> 30);
      else ease_nxt = ALPHA_ONE - 17'(cube_r >> 33);
      estep_nxt = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      estep_r <= '0;
      edone_r <= 1'b0;
    end else begin
      estep_r <= estep_nxt;
      edone_r <= (estep_r == 3'd3);
    end
    eu_r <= eu_nxt;
    sq_r <= sq_nxt;
    cube_r <= cube_nxt;
    ease_r <= ease_nxt;
    rising_r <= rising_nxt;
    lowhalf_r <= lowhalf_nxt;
  end

  // components: one axis at a time, the squash and lerp multiplies shared by all axes
  logic [1:0]  axis_r, axis_nxt;
  logic [2:0]  cstep_r, cstep_nxt;
  logic        cbusy_r, cbusy_nxt;
  logic        cdone_r, cdone_nxt;
  logic signed [50:0] prod_r, prod_nxt;
  logic signed [31:0] sq32_r, sq32_nxt;
  logic signed [50:0] lp_r, lp_nxt;
  logic signed [31:0] rx_r, ry_r, rz_r;
  logic signed [31:0] res_nxt;
  logic signed [31:0] b_sel;
  logic [18:0]        m_sel;
  logic signed [34:0] fl;
  logic signed [32:0] dd;
  logic signed [33:0] sum;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return 32'sh7fffffff;
    if (v < -35'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_comb begin
    case (axis_r)
      2'd0:    begin b_sel = base_x_i; m_sel = mult_x_i; end
      2'd1:    begin b_sel = base_y_i; m_sel = mult_y_i; end
      default: begin b_sel = base_z_i; m_sel = mult_z_i; end
    endcase
  end

  always_comb begin
    axis_nxt = axis_r;
    cstep_nxt = cstep_r;
    cbusy_nxt = cbusy_r;
    cdone_nxt = 1'b0;
    prod_nxt = prod_r;
    sq32_nxt = sq32_r;
    lp_nxt = lp_r;
    res_nxt = b_sel;
    fl = '0;
    dd = '0;
    sum = '0;
    if (cmd_i.comp_go) begin
      axis_nxt = 2'd0;
      cstep_nxt = 3'd0;
      cbusy_nxt = 1'b1;
    end else if (cbusy_r) begin
      case (cstep_r)
        3'd0: begin
          prod_nxt = 51'(b_sel) * $signed({1'b0, m_sel});
          cstep_nxt = 3'd1;
        end
        3'd1: begin
          fl = 35'(prod_r >>> FRAC_BITS);
          sq32_nxt = sat32(fl);
          cstep_nxt = 3'd2;
        end
        3'd2: begin
          if (cmd_i.phase == PH_IN) dd = 33'(sq32_r) - 33'(b_sel);
          else dd = 33'(b_sel) - 33'(sq32_r);
          lp_nxt = 51'(dd) * $signed({1'b0, ease_r});
          cstep_nxt = 3'd3;
        end
        default: begin
          if (cmd_i.phase == PH_IN) sum = 34'(b_sel) + 34'(lp_r >>> 16);
          else sum = 34'(sq32_r) + 34'(lp_r >>> 16);
          case (cmd_i.phase)
            PH_HOLD: res_nxt = sq32_r;
            PH_BASE: res_nxt = b_sel;
            default: res_nxt = sat32(35'(sum));
          endcase
          cstep_nxt = 3'd0;
          if (axis_r == 2'd2) begin
            cbusy_nxt = 1'b0;
            cdone_nxt = 1'b1;
          end
          axis_nxt = axis_r + 2'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cbusy_r <= 1'b0;
      cdone_r <= 1'b0;
      cstep_r <= '0;
      axis_r <= '0;
    end else begin
      cbusy_r <= cbusy_nxt;
      cdone_r <= cdone_nxt;
      cstep_r <= cstep_nxt;
      axis_r <= axis_nxt;
    end
    prod_r <= prod_nxt;
    sq32_r <= sq32_nxt;
    lp_r <= lp_nxt;
    if (cbusy_r && cstep_r == 3'd3) begin
      case (axis_r)
        2'd0:    rx_r <= res_nxt;
        2'd1:    ry_r <= res_nxt;
        default: rz_r <= res_nxt;
      endcase
    end
  end

  assign res_x_o = rx_r;
  assign res_y_o = ry_r;
  assign res_z_o = rz_r;
  assign stat_o.div_done = ddone_r;
  assign stat_o.ease_done = edone_r;
  assign stat_o.comp_done = cdone_r;
endmodule

>>> design/hsse_ctrl.sv
// controller: envelope state, request sequencing and result register
module hsse_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [19:0]        in_delta_us,
  input  logic               in_hit_ok,
  input  logic [20:0]        in_t_in,
  input  logic [20:0]        hold_t,
  input  logic [20:0]        rec_t,
  input  logic [22:0]        cool_t,
  input  logic [1:0]         mode,
  output logic               cap_base,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_scale_write,
  output logic               out_busy_res,
  output logic               out_hit_taken,
  output logic               res_sel_base,
  output hsse_pkg::hsse_cmd_t  cmd_o,
  input  hsse_pkg::hsse_stat_t stat_i,
  output logic [22:0]        t_o,
  output logic [20:0]        len_o
);
  import hsse_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_EASE = 3'd2;
  localparam logic [2:0] S_COMP = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic        running_r, running_nxt;
  logic [22:0] elapsed_r, elapsed_nxt;
  logic [22:0] cool_r, cool_nxt;
  logic        known_r, known_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [22:0] t_r, t_nxt;
  logic [20:0] len_r, len_nxt;
  logic        wr_r, wr_nxt, busy_r, busy_nxt, taken_r, taken_nxt;
  logic        bsel_r, bsel_nxt;
  logic        acc;
  logic [22:0] total;
  logic [23:0] esum;
  logic [22:0] enew;
  logic [22:0] ih;

  assign acc = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign total = 23'(in_t_in) + 23'(hold_t) + 23'(rec_t);
  assign ih = 23'(in_t_in) + 23'(hold_t);
  assign esum = 24'(elapsed_r) + 24'(in_delta_us);
  assign enew = esum[23] ? ELAPSED_MAX : esum[22:0];

  always_comb begin
    state_nxt = state_r;
    running_nxt = running_r;
    elapsed_nxt = elapsed_r;
    cool_nxt = cool_r;
    known_nxt = known_r;
    phase_nxt = phase_r;
    t_nxt = t_r;
    len_nxt = len_r;
    wr_nxt = wr_r;
    busy_nxt = busy_r;
    taken_nxt = taken_r;
    bsel_nxt = bsel_r;
    cap_base = 1'b0;
    cmd_o = '0;
    cmd_o.phase = phase_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          wr_nxt = 1'b0;
          taken_nxt = 1'b0;
          bsel_nxt = 1'b1;
          state_nxt = S_OUT;
          case (in_cmd)
            CMD_TICK: begin
              cool_nxt = (cool_r > 23'(in_delta_us)) ? cool_r - 23'(in_delta_us) : '0;
              if (running_r) begin
                wr_nxt = 1'b1;
                if (total == 23'd0) begin
                  running_nxt = 1'b0;
                end else begin
                  elapsed_nxt = enew;
                  if (in_t_in != 21'd0 && enew < 23'(in_t_in)) begin
                    phase_nxt = PH_IN;
                    t_nxt = enew;
                    len_nxt = in_t_in;
                    bsel_nxt = 1'b0;
                    state_nxt = S_DIV;
                  end else if (enew < ih) begin
                    phase_nxt = PH_HOLD;
                    bsel_nxt = 1'b0;
                    state_nxt = S_COMP;
                  end else if (enew >= total) begin
                    running_nxt = 1'b0;
                    elapsed_nxt = '0;
                  end else begin
                    phase_nxt = PH_REC;
                    t_nxt = enew - ih;
                    len_nxt = rec_t;
                    bsel_nxt = 1'b0;
                    state_nxt = S_DIV;
                  end
                end
              end
            end
            CMD_HIT: begin
              if (in_hit_ok && cool_r == 23'd0 && (!running_r || mode[0])) begin
                if (!running_r) begin
                  cap_base = 1'b1;
                  known_nxt = 1'b1;
                end
                running_nxt = 1'b1;
                elapsed_nxt = '0;
                cool_nxt = cool_t;
                taken_nxt = 1'b1;
              end
            end
            CMD_END: begin
              wr_nxt = mode[1] && known_r;
              running_nxt = 1'b0;
              elapsed_nxt = '0;
            end
            default: ;
          endcase
          busy_nxt = running_nxt;
          if (state_nxt == S_DIV) cmd_o.div_start = 1'b1;
          if (state_nxt == S_COMP) cmd_o.comp_go = 1'b1;
          cmd_o.phase = phase_nxt;
        end
      end
      S_DIV: if (stat_i.div_done) begin
        cmd_o.ease_go = 1'b1;
        state_nxt = S_EASE;
      end
      S_EASE: if (stat_i.ease_done) begin
        cmd_o.comp_go = 1'b1;
        state_nxt = S_COMP;
      end
      S_COMP: if (stat_i.comp_done) state_nxt = S_OUT;
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      running_r <= 1'b0;
      elapsed_r <= '0;
      cool_r <= '0;
      known_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      running_r <= running_nxt;
      elapsed_r <= elapsed_nxt;
      cool_r <= cool_nxt;
      known_r <= known_nxt;
    end
    phase_r <= phase_nxt;
    t_r <= t_nxt;
    len_r <= len_nxt;
    wr_r <= wr_nxt;
    busy_r <= busy_nxt;
    taken_r <= taken_nxt;
    bsel_r <= bsel_nxt;
  end

  assign out_valid = (state_r == S_OUT);
  assign out_scale_write = wr_r;
  assign out_busy_res = busy_r;
  assign out_hit_taken = taken_r;
  assign res_sel_base = bsel_r;
  // divider start samples the operands of the request being accepted
  assign t_o = t_nxt;
  assign len_o = len_nxt;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_scale_write))
    else $error("result dropped");
  a_comp_state: assert property (@(posedge clk) disable iff (!rst_n)
    stat_i.comp_done |-> state_r == S_COMP)
    else $error("components finished outside compute");
  a_taken_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit_taken |-> out_busy_res) else $error("hit without run");
endmodule
